/* hw/rtl/chc_pkg.sv */
// Shared types, register indexes and reset values for the climate hysteresis controller.
`timescale 1ns / 1ps

package chc_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 14;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TEMP_LOW  = 3'd0,
    CFG_TEMP_HIGH = 3'd1,
    CFG_TEMP_WIN  = 3'd2,
    CFG_HUM_HIGH  = 3'd3,
    CFG_HUM_WIN   = 3'd4,
    CFG_CO2_LOW   = 3'd5,
    CFG_CO2_WIN   = 3'd6
  } chc_cfg_idx_e;

  typedef enum logic [1:0] {
    PH_NORMAL = 2'd0,
    PH_VENT   = 2'd1,
    PH_HEAT   = 2'd2,
    PH_COOL   = 2'd3
  } chc_phase_e;

  localparam logic [1:0] CMD_OFF = 2'd0;
  localparam logic [1:0] CMD_ON  = 2'd1;

  localparam logic signed [7:0] TempLowRst  = 8'sd18;
  localparam logic signed [7:0] TempHighRst = 8'sd28;
  localparam logic [4:0]        TempWinRst  = 5'd1;
  localparam logic [6:0]        HumHighRst  = 7'd85;
  localparam logic [4:0]        HumWinRst   = 5'd5;
  localparam logic [13:0]       Co2LowRst   = 14'd400;
  localparam logic [9:0]        Co2WinRst   = 10'd50;

  typedef struct packed {
    logic signed [7:0] temp_low_limit;
    logic signed [7:0] temp_high_limit;
    logic [4:0]        temp_window;
    logic [6:0]        hum_high_limit;
    logic [4:0]        hum_window;
    logic [13:0]       co2_low_limit;
    logic [9:0]        co2_window;
  } chc_cfg_t;

  typedef struct packed {
    logic signed [7:0] temp_c;
    logic [6:0]        hum_pct;
    logic [15:0]       co2_ppm;
    logic              temp_fault;
    logic              hum_fault;
    logic              co2_fault;
    logic              link_up;
    logic              manual_request;
    logic [1:0]        manual_fan_cmd;
    logic [1:0]        manual_heat_cmd;
  } chc_item_t;

endpackage

/* hw/rtl/climate_hysteresis_controller.sv */
// Top level: input stage, configuration registers and controller.
//
// Channel | Direction | Handshake               | Payload
// in      | sink      | in_valid_i / in_stall_o | sensor readings, faults, link, manual cmds
// out     | source    | out_valid_o/out_stall_i | fan_on, heater_on, manual_active, phase
// cfg     | sink      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One transaction per cycle sustained while out_stall_i stays low.
// The input register feeds one level of compares and the state update, whose
// registers are the result register.
// Reset (async, active low) restores default limits and automatic/normal/off state.
// A stalled output holds its result; the input stage still takes one more transaction.
// cfg_ready_o is always high.
`timescale 1ns / 1ps

module climate_hysteresis_controller import chc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [7:0]   temp_c_i,
  input  logic [6:0]          hum_pct_i,
  input  logic [15:0]         co2_ppm_i,
  input  logic                temp_fault_i,
  input  logic                hum_fault_i,
  input  logic                co2_fault_i,
  input  logic                link_up_i,
  input  logic                manual_request_i,
  input  logic [1:0]          manual_fan_cmd_i,
  input  logic [1:0]          manual_heat_cmd_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                fan_on_o,
  output logic                heater_on_o,
  output logic                manual_active_o,
  output logic [1:0]          control_phase_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  chc_cfg_t  cfg;
  chc_item_t item_q, item_d;
  logic      in_valid_q, in_valid_d;
  logic      take, load;

  assign item_d = '{
    temp_c:          temp_c_i,
    hum_pct:         hum_pct_i,
    co2_ppm:         co2_ppm_i,
    temp_fault:      temp_fault_i,
    hum_fault:       hum_fault_i,
    co2_fault:       co2_fault_i,
    link_up:         link_up_i,
    manual_request:  manual_request_i,
    manual_fan_cmd:  manual_fan_cmd_i,
    manual_heat_cmd: manual_heat_cmd_i
  };

  assign in_stall_o = in_valid_q && !take;
  assign load       = in_valid_i && !in_stall_o;
  assign in_valid_d = load || (in_valid_q && !take);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_d;
    end
  end

  chc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  chc_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .item_valid_i    (in_valid_q),
    .item_i          (item_q),
    .take_o          (take),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .fan_on_o        (fan_on_o),
    .heater_on_o     (heater_on_o),
    .manual_active_o (manual_active_o),
    .control_phase_o (control_phase_o)
  );

endmodule

/* hw/rtl/chc_cfg_regs.sv */
// Configuration register file: limits and hysteresis windows.
`timescale 1ns / 1ps

module chc_cfg_regs import chc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output chc_cfg_t            cfg_o
);

  chc_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_TEMP_LOW:  cfg_d.temp_low_limit  = $signed(cfg_data_i[7:0]);
        CFG_TEMP_HIGH: cfg_d.temp_high_limit = $signed(cfg_data_i[7:0]);
        CFG_TEMP_WIN:  cfg_d.temp_window     = cfg_data_i[4:0];
        CFG_HUM_HIGH:  cfg_d.hum_high_limit  = cfg_data_i[6:0];
        CFG_HUM_WIN:   cfg_d.hum_window      = cfg_data_i[4:0];
        CFG_CO2_LOW:   cfg_d.co2_low_limit   = cfg_data_i[13:0];
        CFG_CO2_WIN:   cfg_d.co2_window      = cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.temp_low_limit  <= TempLowRst;
      cfg_q.temp_high_limit <= TempHighRst;
      cfg_q.temp_window     <= TempWinRst;
      cfg_q.hum_high_limit  <= HumHighRst;
      cfg_q.hum_window      <= HumWinRst;
      cfg_q.co2_low_limit   <= Co2LowRst;
      cfg_q.co2_window      <= Co2WinRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hw/rtl/chc_ctrl.sv */
// Mode and hysteresis state update; the state registers double as the result register.
`timescale 1ns / 1ps

module chc_ctrl import chc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  chc_cfg_t   cfg_i,
  input  logic       item_valid_i,
  input  chc_item_t  item_i,
  output logic       take_o,
  input  logic       out_stall_i,
  output logic       out_valid_o,
  output logic       fan_on_o,
  output logic       heater_on_o,
  output logic       manual_active_o,
  output logic [1:0] control_phase_o
);

  logic       out_valid_q, out_valid_d;
  logic       manual_q, manual_d;
  logic       pend_q, pend_d;
  chc_phase_e phase_q, phase_d;
  logic       fan_q, fan_d;
  logic       heat_q, heat_d;
  logic       take;

  // Thresholds in signed arithmetic wide enough for every register value
  logic signed [9:0]  t_val, t_lo_m, t_lo_p, t_hi_m, t_hi_p;
  logic signed [8:0]  h_val, h_hi_m, h_hi_p;
  logic signed [17:0] c_val, c_lo_m, c_lo_p;
  logic               any_fault, link, tf;
  logic               vent_on, heat_on, cool_on, vent_off, heat_off, cool_off;

  assign t_val  = $signed({{2{item_i.temp_c[7]}}, item_i.temp_c});
  assign t_lo_m = $signed({{2{cfg_i.temp_low_limit[7]}}, cfg_i.temp_low_limit})
                - $signed({6'b0, cfg_i.temp_window[4:1]});
  assign t_lo_p = $signed({{2{cfg_i.temp_low_limit[7]}}, cfg_i.temp_low_limit})
                + $signed({6'b0, cfg_i.temp_window[4:1]});
  assign t_hi_m = $signed({{2{cfg_i.temp_high_limit[7]}}, cfg_i.temp_high_limit})
                - $signed({6'b0, cfg_i.temp_window[4:1]});
  assign t_hi_p = $signed({{2{cfg_i.temp_high_limit[7]}}, cfg_i.temp_high_limit})
                + $signed({6'b0, cfg_i.temp_window[4:1]});

  assign h_val  = $signed({2'b0, item_i.hum_pct});
  assign h_hi_m = $signed({2'b0, cfg_i.hum_high_limit}) - $signed({5'b0, cfg_i.hum_window[4:1]});
  assign h_hi_p = $signed({2'b0, cfg_i.hum_high_limit}) + $signed({5'b0, cfg_i.hum_window[4:1]});

  assign c_val  = $signed({2'b0, item_i.co2_ppm});
  assign c_lo_m = $signed({4'b0, cfg_i.co2_low_limit}) - $signed({9'b0, cfg_i.co2_window[9:1]});
  assign c_lo_p = $signed({4'b0, cfg_i.co2_low_limit}) + $signed({9'b0, cfg_i.co2_window[9:1]});

  assign tf        = item_i.temp_fault;
  assign link      = item_i.link_up;
  assign any_fault = item_i.temp_fault | item_i.hum_fault | item_i.co2_fault;

  assign vent_on  = ((c_val < c_lo_m) || (h_val > h_hi_p)) && (t_val >= t_lo_m)
                  && !any_fault && link;
  assign heat_on  = (t_val < t_lo_m) && !tf && link;
  assign cool_on  = (t_val > t_hi_p) && !tf && link;
  assign vent_off = ((c_val > c_lo_p) && (h_val < h_hi_m)) || (t_val < t_lo_m)
                  || any_fault || !link;
  assign heat_off = (t_val > t_lo_p) || tf || !link;
  assign cool_off = (t_val < t_hi_m) || tf || !link;

  // Advance when the result slot is empty or being drained
  assign take   = item_valid_i && (!out_valid_q || !out_stall_i);
  assign take_o = take;

  always_comb begin
    manual_d    = manual_q;
    pend_d      = pend_q;
    phase_d     = phase_q;
    fan_d       = fan_q;
    heat_d      = heat_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (take) begin
      out_valid_d = 1'b1;
      if (!manual_q) begin
        if (item_i.manual_request || pend_q) begin
          // Entering manual or first auto tick after it: force everything off
          manual_d = item_i.manual_request;
          pend_d   = 1'b0;
          fan_d    = 1'b0;
          heat_d   = 1'b0;
          phase_d  = PH_NORMAL;
        end else begin
          case (phase_q)
            PH_NORMAL: begin
              if (vent_on) begin
                fan_d   = 1'b1;
                phase_d = PH_VENT;
              end else if (heat_on) begin
                heat_d  = 1'b1;
                phase_d = PH_HEAT;
              end else if (cool_on) begin
                fan_d   = 1'b1;
                phase_d = PH_COOL;
              end
            end
            PH_VENT: begin
              if (vent_off) begin
                fan_d   = 1'b0;
                phase_d = PH_NORMAL;
              end
            end
            PH_HEAT: begin
              if (heat_off) begin
                heat_d  = 1'b0;
                phase_d = PH_NORMAL;
              end
            end
            default: begin
              if (cool_off) begin
                fan_d   = 1'b0;
                phase_d = PH_NORMAL;
              end
            end
          endcase
        end
      end else if (!item_i.manual_request || !link) begin
        // Leave manual; relays hold until the next auto tick
        manual_d = 1'b0;
        pend_d   = 1'b1;
      end else begin
        if (item_i.manual_fan_cmd == CMD_OFF || item_i.manual_fan_cmd == CMD_ON) begin
          fan_d = (item_i.manual_fan_cmd == CMD_ON);
        end
        if (item_i.manual_heat_cmd == CMD_OFF || item_i.manual_heat_cmd == CMD_ON) begin
          heat_d = (item_i.manual_heat_cmd == CMD_ON);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      manual_q    <= 1'b0;
      pend_q      <= 1'b0;
      phase_q     <= PH_NORMAL;
      fan_q       <= 1'b0;
      heat_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      manual_q    <= manual_d;
      pend_q      <= pend_d;
      phase_q     <= phase_d;
      fan_q       <= fan_d;
      heat_q      <= heat_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign fan_on_o        = fan_q;
  assign heater_on_o     = heat_q;
  assign manual_active_o = manual_q;
  assign control_phase_o = phase_q;

  a_pend_only_in_auto: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !manual_q)
    else $error("pending reset mark set while in manual mode");

  a_auto_relays_match_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!manual_q && !pend_q) |->
      (fan_q == (phase_q == PH_VENT || phase_q == PH_COOL)) &&
      (heat_q == (phase_q == PH_HEAT)))
    else $error("relays disagree with hysteresis phase in automatic mode");

  a_enter_manual_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !manual_q && item_i.manual_request) |=>
      (manual_q && !pend_q && !fan_q && !heat_q && phase_q == PH_NORMAL))
    else $error("entering manual mode did not force actuators off");

  a_state_holds_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !take |=> $stable({manual_q, pend_q, phase_q, fan_q, heat_q}))
    else $error("controller state changed without a transaction");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the climate hysteresis controller: directed table then random ticks.
`timescale 1ns / 1ps

module testbench;
  import chc_pkg::*;

  typedef struct packed {
    logic       fan_on;
    logic       heater_on;
    logic       manual_active;
    chc_phase_e phase;
  } relay_out_t;

  typedef struct {
    chc_item_t  item;
    bit         typed;
    relay_out_t want;
  } dir_row_t;

  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 3'd7;
  localparam logic [1:0] CMD_NONE = 2'd2;
  localparam logic [1:0] CMD_RSVD = 2'd3;
  localparam int RandTicksPerPhase = 250;
  localparam int NumPhases = 7;
  localparam int SqueezePhase = 3;
  localparam int SqueezeTicks = 200;
  localparam int SqueezeCycles = 100;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic signed [7:0]   temp_c_i;
  logic [6:0]          hum_pct_i;
  logic [15:0]         co2_ppm_i;
  logic                temp_fault_i;
  logic                hum_fault_i;
  logic                co2_fault_i;
  logic                link_up_i;
  logic                manual_request_i;
  logic [1:0]          manual_fan_cmd_i;
  logic [1:0]          manual_heat_cmd_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                fan_on_o;
  logic                heater_on_o;
  logic                manual_active_o;
  logic [1:0]          control_phase_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  climate_hysteresis_controller i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .temp_c_i         (temp_c_i),
    .hum_pct_i        (hum_pct_i),
    .co2_ppm_i        (co2_ppm_i),
    .temp_fault_i     (temp_fault_i),
    .hum_fault_i      (hum_fault_i),
    .co2_fault_i      (co2_fault_i),
    .link_up_i        (link_up_i),
    .manual_request_i (manual_request_i),
    .manual_fan_cmd_i (manual_fan_cmd_i),
    .manual_heat_cmd_i(manual_heat_cmd_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .fan_on_o         (fan_on_o),
    .heater_on_o      (heater_on_o),
    .manual_active_o  (manual_active_o),
    .control_phase_o  (control_phase_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Shadow copy of the controller state and limits
  chc_cfg_t   limits_shadow;
  logic       mode_manual;
  logic       pend_reset;
  chc_phase_e phase_state;
  logic       fan_relay_q;
  logic       heat_relay_q;

  relay_out_t relay_expect_q[$];
  int         fail_cnt;
  logic       squeeze_req;

  // Random walk of the readings, kept across ticks
  int walk_t;
  int walk_h;
  int walk_c;
  bit want_manual;

  function automatic int idle_len();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 55) return 0;
    if (r < 90) return int'($urandom_range(1, 3));
    if (r < 97) return int'($urandom_range(4, 12));
    return int'($urandom_range(20, 40));
  endfunction

  function automatic int near(int base, int span);
    return base - span + int'($urandom_range(0, 2 * span));
  endfunction

  function automatic int clip(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic chc_item_t mk_tick(int t, int h, int c, bit tf, bit hf, bit cf,
                                        bit link, bit req, logic [1:0] fc, logic [1:0] hc);
    chc_item_t it;
    it.temp_c          = t[7:0];
    it.hum_pct         = h[6:0];
    it.co2_ppm         = c[15:0];
    it.temp_fault      = tf;
    it.hum_fault       = hf;
    it.co2_fault       = cf;
    it.link_up         = link;
    it.manual_request  = req;
    it.manual_fan_cmd  = fc;
    it.manual_heat_cmd = hc;
    return it;
  endfunction

  function automatic relay_out_t mk_out(bit f, bit h, bit m, chc_phase_e p);
    relay_out_t r;
    r.fan_on        = f;
    r.heater_on     = h;
    r.manual_active = m;
    r.phase         = p;
    return r;
  endfunction

  // Advance the shadow state by one tick and return the relay outputs
  task automatic step_climate(input chc_item_t it, output relay_out_t res);
    int  t, h, c, tlo, thi, hhi, clo, th, hh, ch;
    bit  any_fault, link;
    t         = int'($signed(it.temp_c));
    h         = int'(it.hum_pct);
    c         = int'(it.co2_ppm);
    tlo       = int'($signed(limits_shadow.temp_low_limit));
    thi       = int'($signed(limits_shadow.temp_high_limit));
    hhi       = int'(limits_shadow.hum_high_limit);
    clo       = int'(limits_shadow.co2_low_limit);
    th        = int'(limits_shadow.temp_window) >> 1;
    hh        = int'(limits_shadow.hum_window) >> 1;
    ch        = int'(limits_shadow.co2_window) >> 1;
    any_fault = it.temp_fault | it.hum_fault | it.co2_fault;
    link      = it.link_up;
    if (!mode_manual) begin
      if (it.manual_request) begin
        mode_manual = 1'b1;
        pend_reset  = 1'b1;
      end
      if (pend_reset) begin
        fan_relay_q  = 1'b0;
        heat_relay_q = 1'b0;
        phase_state  = PH_NORMAL;
        pend_reset   = 1'b0;
      end else begin
        case (phase_state)
          PH_NORMAL: begin
            if ((c < clo - ch || h > hhi + hh) && t >= tlo - th && !any_fault && link) begin
              fan_relay_q = 1'b1;
              phase_state = PH_VENT;
            end else if (t < tlo - th && !it.temp_fault && link) begin
              heat_relay_q = 1'b1;
              phase_state  = PH_HEAT;
            end else if (t > thi + th && !it.temp_fault && link) begin
              fan_relay_q = 1'b1;
              phase_state = PH_COOL;
            end
          end
          PH_VENT: begin
            if ((c > clo + ch && h < hhi - hh) || t < tlo - th || any_fault || !link) begin
              fan_relay_q = 1'b0;
              phase_state = PH_NORMAL;
            end
          end
          PH_HEAT: begin
            if (t > tlo + th || it.temp_fault || !link) begin
              heat_relay_q = 1'b0;
              phase_state  = PH_NORMAL;
            end
          end
          default: begin
            if (t < thi - th || it.temp_fault || !link) begin
              fan_relay_q = 1'b0;
              phase_state = PH_NORMAL;
            end
          end
        endcase
      end
    end else if (!it.manual_request || !link) begin
      // leave manual; relays hold until the next automatic tick clears them
      mode_manual = 1'b0;
      pend_reset  = 1'b1;
    end else begin
      if (it.manual_fan_cmd == CMD_ON || it.manual_fan_cmd == CMD_OFF)
        fan_relay_q = (it.manual_fan_cmd == CMD_ON);
      if (it.manual_heat_cmd == CMD_ON || it.manual_heat_cmd == CMD_OFF)
        heat_relay_q = (it.manual_heat_cmd == CMD_ON);
    end
    res = mk_out(fan_relay_q, heat_relay_q, mode_manual, phase_state);
  endtask

  task automatic send_tick(input chc_item_t it, input bit typed, input relay_out_t typed_want);
    relay_out_t pred;
    in_valid_i        <= 1'b1;
    temp_c_i          <= it.temp_c;
    hum_pct_i         <= it.hum_pct;
    co2_ppm_i         <= it.co2_ppm;
    temp_fault_i      <= it.temp_fault;
    hum_fault_i       <= it.hum_fault;
    co2_fault_i       <= it.co2_fault;
    link_up_i         <= it.link_up;
    manual_request_i  <= it.manual_request;
    manual_fan_cmd_i  <= it.manual_fan_cmd;
    manual_heat_cmd_i <= it.manual_heat_cmd;
    do @(posedge clk_i); while (in_stall_o);
    step_climate(it, pred);
    relay_expect_q.push_back(typed ? typed_want : pred);
  endtask

  task automatic idle_in();
    int n;
    n = idle_len();
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (relay_expect_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int value);
    logic [CfgDataW-1:0] data;
    // fill bits above the register width with noise
    data = CfgDataW'($urandom);
    case (idx)
      CFG_TEMP_LOW, CFG_TEMP_HIGH: data[7:0] = value[7:0];
      CFG_TEMP_WIN, CFG_HUM_WIN:   data[4:0] = value[4:0];
      CFG_HUM_HIGH:                data[6:0] = value[6:0];
      CFG_CO2_LOW:                 data      = value[13:0];
      CFG_CO2_WIN:                 data[9:0] = value[9:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_TEMP_LOW:  limits_shadow.temp_low_limit  = data[7:0];
      CFG_TEMP_HIGH: limits_shadow.temp_high_limit = data[7:0];
      CFG_TEMP_WIN:  limits_shadow.temp_window     = data[4:0];
      CFG_HUM_HIGH:  limits_shadow.hum_high_limit  = data[6:0];
      CFG_HUM_WIN:   limits_shadow.hum_window      = data[4:0];
      CFG_CO2_LOW:   limits_shadow.co2_low_limit   = data[13:0];
      CFG_CO2_WIN:   limits_shadow.co2_window      = data[9:0];
      default: ;
    endcase
  endtask

  task automatic load_limits(input int tlo, input int thi, input int tw, input int hhi,
                             input int hw, input int clo, input int cw);
    write_reg(CFG_TEMP_LOW, tlo);
    write_reg(CFG_TEMP_HIGH, thi);
    write_reg(CFG_TEMP_WIN, tw);
    write_reg(CFG_HUM_HIGH, hhi);
    write_reg(CFG_HUM_WIN, hw);
    write_reg(CFG_CO2_LOW, clo);
    write_reg(CFG_CO2_WIN, cw);
    write_reg(CfgIdxSpare, 0);
    cfg_valid_i <= 1'b0;
  endtask

  // Readings drift slowly and now and then jump next to a threshold or to a random value
  task automatic make_random_tick(output chc_item_t it);
    int tlo, thi, th, hhi, hh, clo, ch;
    tlo = int'($signed(limits_shadow.temp_low_limit));
    thi = int'($signed(limits_shadow.temp_high_limit));
    th  = int'(limits_shadow.temp_window) >> 1;
    hhi = int'(limits_shadow.hum_high_limit);
    hh  = int'(limits_shadow.hum_window) >> 1;
    clo = int'(limits_shadow.co2_low_limit);
    ch  = int'(limits_shadow.co2_window) >> 1;
    if ($urandom_range(0, 15) == 0) begin
      case ($urandom_range(0, 3))
        0:       walk_t = near(tlo, th + 3);
        1:       walk_t = near(thi, th + 3);
        default: walk_t = int'($urandom_range(0, 255)) - 128;
      endcase
    end else begin
      walk_t = walk_t + int'($urandom_range(0, 4)) - 2;
    end
    if ($urandom_range(0, 15) == 0)
      walk_h = ($urandom_range(0, 2) != 0) ? near(hhi, hh + 3) : int'($urandom_range(0, 100));
    else
      walk_h = walk_h + int'($urandom_range(0, 4)) - 2;
    if ($urandom_range(0, 15) == 0)
      walk_c = ($urandom_range(0, 2) != 0) ? near(clo, ch + 5) : int'($urandom_range(0, 65535));
    else
      walk_c = walk_c + int'($urandom_range(0, 20)) - 10;
    walk_t = clip(walk_t, -128, 127);
    walk_h = clip(walk_h, 0, 100);
    walk_c = clip(walk_c, 0, 65535);
    if ($urandom_range(0, 39) == 0) want_manual = !want_manual;
    it = mk_tick(walk_t, walk_h, walk_c,
                 $urandom_range(0, 9) == 0, $urandom_range(0, 11) == 0,
                 $urandom_range(0, 11) == 0, $urandom_range(0, 11) != 0,
                 want_manual ^ ($urandom_range(0, 49) == 0),
                 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
  endtask

  // Check every result transaction against the oldest expectation
  always @(posedge clk_i) begin : result_check
    relay_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (relay_expect_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("%0t: result transaction with nothing expected", $realtime);
      end else begin
        want = relay_expect_q.pop_front();
        if (fan_on_o !== want.fan_on || heater_on_o !== want.heater_on ||
            manual_active_o !== want.manual_active || control_phase_o !== want.phase) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("%0t: mismatch fan %b/%b heater %b/%b manual %b/%b phase %0d/%0d",
                     $realtime, want.fan_on, fan_on_o, want.heater_on, heater_on_o,
                     want.manual_active, manual_active_o, want.phase, control_phase_o);
        end
      end
    end
  end

  // Output side: random stalls, plus one long hold-off to back up the input
  initial begin : result_sink
    int  n;
    bit  squeeze_done;
    out_stall_i  = 1'b0;
    squeeze_done = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (squeeze_req && !squeeze_done) begin
        squeeze_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (SqueezeCycles) @(posedge clk_i);
      end else begin
        n = idle_len();
        if (n > 0) begin
          out_stall_i <= 1'b1;
          repeat (n) @(posedge clk_i);
        end
      end
      out_stall_i <= 1'b0;
      n = ($urandom_range(0, 9) == 0) ? int'($urandom_range(20, 80)) : int'($urandom_range(1, 6));
      repeat (n) @(posedge clk_i);
    end
  end

  initial begin : stimulus
    dir_row_t   rows[$];
    chc_item_t  it;
    relay_out_t none;
    bit         burst;
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    temp_c_i          = '0;
    hum_pct_i         = '0;
    co2_ppm_i         = '0;
    temp_fault_i      = 1'b0;
    hum_fault_i       = 1'b0;
    co2_fault_i       = 1'b0;
    link_up_i         = 1'b0;
    manual_request_i  = 1'b0;
    manual_fan_cmd_i  = CMD_NONE;
    manual_heat_cmd_i = CMD_NONE;
    cfg_valid_i       = 1'b0;
    cfg_index_i       = CFG_TEMP_LOW;
    cfg_data_i        = '0;
    squeeze_req       = 1'b0;
    fail_cnt          = 0;
    none              = '0;
    burst             = 1'b0;
    walk_t            = 22;
    walk_h            = 50;
    walk_c            = 800;
    want_manual       = 1'b0;

    limits_shadow.temp_low_limit  = TempLowRst;
    limits_shadow.temp_high_limit = TempHighRst;
    limits_shadow.temp_window     = TempWinRst;
    limits_shadow.hum_high_limit  = HumHighRst;
    limits_shadow.hum_window      = HumWinRst;
    limits_shadow.co2_low_limit   = Co2LowRst;
    limits_shadow.co2_window      = Co2WinRst;
    mode_manual  = 1'b0;
    pend_reset   = 1'b0;
    phase_state  = PH_NORMAL;
    fan_relay_q  = 1'b0;
    heat_relay_q = 1'b0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset limits: temperature 18..28 with no margin, humidity 85+-2, CO2 400+-25
    rows.push_back('{mk_tick(22, 50, 800, 0, 0, 0, 1, 0, CMD_NONE, CMD_NONE), 1,
                     mk_out(0, 0, 0, PH_NORMAL)});
    rows.push_back('{mk_tick(-128, 50, 800, 0, 0, 0, 1, 0, CMD_NONE, CMD_NONE), 1,
                     mk_out(0, 1, 0, PH_HEAT)});
    rows.push_back('{mk_tick(127, 50, 800, 0, 0, 0, 1, 0, CMD_NONE, CMD_NONE), 1,
                     mk_out(0, 0, 0, PH_NORMAL)});
    rows.push_back('{mk_tick(127, 50, 800, 0, 0, 0, 1, 0, CMD_NONE, CMD_NONE), 1,
                     mk_out(1, 0, 0, PH_COOL)});
    rows.push_back('{mk_tick(22, 50, 800, 0, 0, 0, 1, 0, CMD_NONE, CMD_NONE), 1,
                     mk_out(0, 0, 0, PH_NORMAL)});
    rows.push_back('{mk_tick(22, 50, 0, 0, 0, 0, 1, 0, CMD_NONE, CMD_NONE), 1,
                     mk_out(1, 0, 0, PH_VENT)});
    rows.push_back('{mk_tick(22, 0, 65535, 0, 0, 0, 1, 0, CMD_NONE, CMD_NONE), 1,
                     mk_out(0, 0, 0, PH_NORMAL)});
    rows.push_back('{mk_tick(22, 100, 65535, 0, 0, 0, 1, 0, CMD_NONE, CMD_NONE), 1,
                     mk_out(1, 0, 0, PH_VENT)});
    rows.push_back('{mk_tick(22, 100, 65535, 0, 0, 1, 1, 0, CMD_NONE, CMD_NONE), 1,
                     mk_out(0, 0, 0, PH_NORMAL)});
    rows.push_back('{mk_tick(10, 50, 800, 1, 0, 0, 1, 0, CMD_NONE, CMD_NONE), 1,
                     mk_out(0, 0, 0, PH_NORMAL)});
    rows.push_back('{mk_tick(10, 50, 800, 0, 0, 0, 0, 0, CMD_NONE, CMD_NONE), 1,
                     mk_out(0, 0, 0, PH_NORMAL)});
    rows.push_back('{mk_tick(10, 50, 800, 0, 1, 0, 1, 0, CMD_NONE, CMD_NONE), 1,
                     mk_out(0, 1, 0, PH_HEAT)});
    // manual entry clears the relays; commands apply from the next tick on
    rows.push_back('{mk_tick(10, 50, 800, 0, 0, 0, 1, 1, CMD_NONE, CMD_NONE), 1,
                     mk_out(0, 0, 1, PH_NORMAL)});
    rows.push_back('{mk_tick(10, 50, 800, 0, 0, 0, 1, 1, CMD_ON, CMD_ON), 1,
                     mk_out(1, 1, 1, PH_NORMAL)});
    rows.push_back('{mk_tick(10, 50, 800, 0, 0, 0, 1, 1, CMD_OFF, CMD_RSVD), 1,
                     mk_out(0, 1, 1, PH_NORMAL)});
    rows.push_back('{mk_tick(10, 50, 800, 0, 0, 0, 1, 1, CMD_RSVD, CMD_OFF), 1,
                     mk_out(0, 0, 1, PH_NORMAL)});
    rows.push_back('{mk_tick(10, 50, 800, 0, 0, 0, 0, 1, CMD_ON, CMD_ON), 1,
                     mk_out(0, 0, 0, PH_NORMAL)});
    rows.push_back('{mk_tick(-128, 50, 800, 0, 0, 0, 1, 0, CMD_NONE, CMD_NONE), 1,
                     mk_out(0, 0, 0, PH_NORMAL)});
    rows.push_back('{mk_tick(22, 50, 800, 0, 0, 0, 1, 1, CMD_ON, CMD_NONE), 1,
                     mk_out(0, 0, 1, PH_NORMAL)});
    rows.push_back('{mk_tick(22, 50, 800, 0, 0, 0, 1, 1, CMD_ON, CMD_NONE), 1,
                     mk_out(1, 0, 1, PH_NORMAL)});
    rows.push_back('{mk_tick(22, 50, 800, 0, 0, 0, 1, 0, CMD_NONE, CMD_NONE), 1,
                     mk_out(1, 0, 0, PH_NORMAL)});
    // re-entry while the clear is still pending
    rows.push_back('{mk_tick(22, 50, 800, 0, 0, 0, 1, 1, CMD_NONE, CMD_NONE), 1,
                     mk_out(0, 0, 1, PH_NORMAL)});
    rows.push_back('{mk_tick(22, 50, 800, 0, 0, 0, 1, 0, CMD_NONE, CMD_NONE), 1,
                     mk_out(0, 0, 0, PH_NORMAL)});
    rows.push_back('{mk_tick(-128, 50, 800, 0, 0, 0, 1, 0, CMD_NONE, CMD_NONE), 1,
                     mk_out(0, 0, 0, PH_NORMAL)});
    rows.push_back('{mk_tick(-128, 50, 800, 0, 0, 0, 1, 0, CMD_NONE, CMD_NONE), 1,
                     mk_out(0, 1, 0, PH_HEAT)});
    rows.push_back('{mk_tick(19, 50, 800, 0, 0, 0, 1, 0, CMD_NONE, CMD_NONE), 0, none});
    rows.push_back('{mk_tick(18, 50, 374, 0, 0, 0, 1, 0, CMD_NONE, CMD_NONE), 0, none});

    foreach (rows[i]) begin
      send_tick(rows[i].item, rows[i].typed, rows[i].want);
      idle_in();
    end
    drain();

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: load_limits(-40, -40, 0, 0, 0, 0, 0);
        1: load_limits(85, 85, 31, 100, 31, 10000, 1023);
        2: load_limits(-128, 127, 31, 127, 31, 16383, 1023);
        3, 4: load_limits(int'($urandom_range(0, 125)) - 40, int'($urandom_range(0, 125)) - 40,
                          int'($urandom_range(0, 31)), int'($urandom_range(0, 100)),
                          int'($urandom_range(0, 31)), int'($urandom_range(0, 10000)),
                          int'($urandom_range(0, 1023)));
        default: load_limits(int'($urandom_range(0, 255)) - 128,
                             int'($urandom_range(0, 255)) - 128,
                             int'($urandom_range(0, 31)), int'($urandom_range(0, 127)),
                             int'($urandom_range(0, 31)), int'($urandom_range(0, 16383)),
                             int'($urandom_range(0, 1023)));
      endcase
      if (p == SqueezePhase) squeeze_req <= 1'b1;
      for (int n = 0; n < RandTicksPerPhase; n++) begin
        make_random_tick(it);
        send_tick(it, 1'b0, none);
        if ($urandom_range(0, 29) == 0) burst = !burst;
        // keep offering back to back in burst mode and for the first SqueezeTicks ticks of the squeeze phase
        if (!burst && !(p == SqueezePhase && n < SqueezeTicks)) idle_in();
      end
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (relay_expect_q.size() != 0) fail_cnt++;
    if (fail_cnt == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/chc_pkg.sv
hw/rtl/chc_cfg_regs.sv
hw/rtl/chc_ctrl.sv
hw/rtl/climate_hysteresis_controller.sv
tb/testbench.sv
